[rtl/ipv4p_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types, constants and a helper function of the IPv4 dotted-address
// parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_SPACE,
    CLS_DOT,
    CLS_X,
    CLS_DEC,
    CLS_HEX,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
  } char_tok_t;

  typedef enum logic [4:0] {
    PH_START    = 5'b00001,
    PH_ZERO     = 5'b00010,
    PH_DIGITS   = 5'b00100,
    PH_DONE_OK  = 5'b01000,
    PH_DONE_BAD = 5'b10000
  } parse_phase_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } number_base_e;

  localparam logic [31:0] ADDR_INVALID = 32'hffff_ffff;

  // Largest value the final part may take after the given number of stored parts.
  function automatic logic [31:0] last_limit(input logic [1:0] parts);
    logic [31:0] lim;
    unique case (parts)
      2'd0:    lim = 32'hffff_ffff;
      2'd1:    lim = 32'h00ff_ffff;
      2'd2:    lim = 32'h0000_ffff;
      default: lim = 32'h0000_00ff;
    endcase
    return lim;
  endfunction

endpackage

[rtl/ipv4p_if.sv]
// ----------------------------------------------------------------------------
// ipv4p_if
// Valid/ready channels of the parser: characters in, addresses out.
// ----------------------------------------------------------------------------
interface ipv4p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ipv4p_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        valid_res;

  modport source (output valid, output address, output valid_res, input ready);
  modport sink   (input valid, input address, input valid_res, output ready);
endinterface

[rtl/ipv4p_front.sv]
// ----------------------------------------------------------------------------
// ipv4p_front
// Accepts characters and turns each into a class and a digit value.
// ----------------------------------------------------------------------------
module ipv4p_front
  import ipv4p_pkg::*;
(
  ipv4p_char_if.sink char_i,
  input  logic       q_full_i,
  output logic       push_o,
  output char_tok_t  tok_o
);

  logic [7:0] c;

  assign c            = char_i.char_code;
  assign char_i.ready = !q_full_i;
  assign push_o       = char_i.valid && !q_full_i;

  always_comb begin
    tok_o.digit = 4'd0;
    priority if (c == 8'd0) begin
      tok_o.cls = CLS_NUL;
    end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      tok_o.cls = CLS_SPACE;
    end else if (c == 8'h2e) begin
      tok_o.cls = CLS_DOT;
    end else if (c == 8'h78 || c == 8'h58) begin
      tok_o.cls = CLS_X;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      tok_o.cls   = CLS_DEC;
      tok_o.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      tok_o.cls   = CLS_HEX;
      tok_o.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      tok_o.cls   = CLS_HEX;
      tok_o.digit = 4'(c - 8'h37);
    end else begin
      tok_o.cls = CLS_OTHER;
    end
  end

endmodule

[rtl/ipv4p_queue.sv]
// ----------------------------------------------------------------------------
// ipv4p_queue
// Short flop-based FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module ipv4p_queue
  import ipv4p_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  char_tok_t tok_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output char_tok_t tok_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  char_tok_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

[rtl/ipv4p_back.sv]
// ----------------------------------------------------------------------------
// ipv4p_back
// Parse state machine, part accumulator and registered result output.
// ----------------------------------------------------------------------------
module ipv4p_back
  import ipv4p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tok_valid_i,
  input  char_tok_t  tok_i,
  output logic       pop_o,
  ipv4p_addr_if.source addr_o
);

  parse_phase_e phase_q, phase_d;
  number_base_e base_q, base_d;
  logic [31:0]  part_q, part_d;
  logic         ovf_q, ovf_d;
  logic         seen_q, seen_d;
  logic [1:0]   parts_q, parts_d;
  logic [23:0]  octets_q, octets_d;

  logic         out_valid_q;
  logic [31:0]  out_addr_q;
  logic         out_ok_q;

  logic [35:0]  prod;
  logic [35:0]  acc_sum;
  logic         final_ok;
  logic [31:0]  final_addr;
  logic         emit, emit_ok;

  assign pop_o = tok_valid_i &&
                 (tok_i.cls != CLS_NUL || !out_valid_q || addr_o.ready);

  always_comb begin
    unique case (base_q)
      BASE_OCT: prod = {part_q, 3'b000, 1'b0} >> 1;
      BASE_HEX: prod = {part_q, 4'b0000};
      default:  prod = {1'b0, part_q, 3'b000} + {3'b000, part_q, 1'b0};
    endcase
    acc_sum = prod + {32'd0, tok_i.digit};
  end

  assign final_ok = seen_q && !ovf_q && (part_q <= last_limit(parts_q));

  always_comb begin
    unique case (parts_q)
      2'd0:    final_addr = part_q;
      2'd1:    final_addr = {octets_q[7:0], 24'd0} | part_q;
      2'd2:    final_addr = {octets_q[15:0], 16'd0} | part_q;
      default: final_addr = {octets_q, 8'd0} | part_q;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    base_d   = base_q;
    part_d   = part_q;
    ovf_d    = ovf_q;
    seen_d   = seen_q;
    parts_d  = parts_q;
    octets_d = octets_q;
    emit     = 1'b0;
    emit_ok  = 1'b0;
    if (pop_o) begin
      unique case (phase_q)
        PH_START: begin
          if (tok_i.cls == CLS_NUL) begin
            emit = 1'b1;
          end else if (tok_i.cls == CLS_DEC && tok_i.digit == 4'd0) begin
            base_d  = BASE_OCT;
            part_d  = '0;
            seen_d  = 1'b1;
            phase_d = PH_ZERO;
          end else if (tok_i.cls == CLS_DEC) begin
            base_d  = BASE_DEC;
            part_d  = {28'd0, tok_i.digit};
            seen_d  = 1'b1;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE_BAD;
          end
        end
        PH_ZERO, PH_DIGITS: begin
          unique case (tok_i.cls)
            CLS_X: begin
              if (phase_q == PH_ZERO) begin
                base_d  = BASE_HEX;
                seen_d  = 1'b0;
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_DONE_BAD;
              end
            end
            CLS_DEC, CLS_HEX: begin
              if ((tok_i.cls == CLS_DEC && base_q == BASE_OCT && tok_i.digit >= 4'd8) ||
                  (tok_i.cls == CLS_HEX && base_q != BASE_HEX)) begin
                phase_d = PH_DONE_BAD;
              end else begin
                part_d  = acc_sum[31:0];
                ovf_d   = ovf_q || (acc_sum[35:32] != 4'd0);
                seen_d  = 1'b1;
                phase_d = PH_DIGITS;
              end
            end
            CLS_DOT: begin
              if (!seen_q || parts_q == 2'd3 || ovf_q || part_q[31:8] != 24'd0) begin
                phase_d = PH_DONE_BAD;
              end else begin
                octets_d = {octets_q[15:0], part_q[7:0]};
                parts_d  = parts_q + 2'd1;
                phase_d  = PH_START;
                base_d   = BASE_DEC;
                part_d   = '0;
                ovf_d    = 1'b0;
                seen_d   = 1'b0;
              end
            end
            CLS_NUL: begin
              emit    = 1'b1;
              emit_ok = final_ok;
            end
            CLS_SPACE: begin
              phase_d = final_ok ? PH_DONE_OK : PH_DONE_BAD;
            end
            default: begin
              phase_d = PH_DONE_BAD;
            end
          endcase
        end
        PH_DONE_OK: begin
          if (tok_i.cls == CLS_NUL) begin
            emit    = 1'b1;
            emit_ok = 1'b1;
          end
        end
        default: begin
          if (tok_i.cls == CLS_NUL) begin
            emit = 1'b1;
          end
          phase_d = PH_DONE_BAD;
        end
      endcase
      if (emit) begin
        phase_d  = PH_START;
        base_d   = BASE_DEC;
        part_d   = '0;
        ovf_d    = 1'b0;
        seen_d   = 1'b0;
        parts_d  = '0;
        octets_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      base_q      <= BASE_DEC;
      part_q      <= '0;
      ovf_q       <= 1'b0;
      seen_q      <= 1'b0;
      parts_q     <= '0;
      octets_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      base_q   <= base_d;
      part_q   <= part_d;
      ovf_q    <= ovf_d;
      seen_q   <= seen_d;
      parts_q  <= parts_d;
      octets_q <= octets_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (addr_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_addr_q <= emit_ok ? final_addr : ADDR_INVALID;
      out_ok_q   <= emit_ok;
    end
  end

  assign addr_o.valid     = out_valid_q;
  assign addr_o.address   = out_addr_q;
  assign addr_o.valid_res = out_ok_q;

endmodule

[rtl/ipv4_dotted_address_parser.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser
// Parses a dotted IPv4 address string, one character per item, and delivers
// one address item at the terminating NUL character.
//
//   Channel   Dir  Payload                      Item
//   in_i      in   char_code[7:0]               one character
//   out_o     out  address[31:0], valid_res     one parsed address
//
// One character is taken per cycle while the queue is not full; the parse state
// machine in the back end updates its accumulator with a single shift-add, so
// the rate is one item per cycle unless the input stalls. With no result waiting
// and nothing queued ahead, a NUL passes the queue, then its result is registered.
// Reset returns the parser to the start of a new string and empties the queue.
// While a result waits at the output, characters still pass to the back end;
// a NUL that reaches the head of the queue holds there, the queue fills
// behind it and the input stalls until the waiting result is taken.
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser
  import ipv4p_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ipv4p_char_if.sink   in_i,
  ipv4p_addr_if.source out_o
);

  logic      push, full, q_valid, pop;
  char_tok_t front_tok, back_tok;

  ipv4p_front u_front (
    .char_i   (in_i),
    .q_full_i (full),
    .push_o   (push),
    .tok_o    (front_tok)
  );

  ipv4p_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (front_tok),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .tok_o   (back_tok)
  );

  ipv4p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (back_tok),
    .pop_o       (pop),
    .addr_o      (out_o)
  );

endmodule

[rtl/ipv4p_checker.sv]
// ----------------------------------------------------------------------------
// ipv4p_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4p_checker
  import ipv4p_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_address_i,
  input logic        out_valid_res_i
);

  // An invalid verdict always carries the all-ones address.
  a_invalid_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_valid_res_i) |-> (out_address_i == ADDR_INVALID))
    else $error("invalid result without all-ones address");

  // The input only backs up after the output was stalled.
  a_ready_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A stalled result holds its payload.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_address_i) && $stable(out_valid_res_i)))
    else $error("stalled result changed");

endmodule

bind ipv4_dotted_address_parser ipv4p_checker u_ipv4p_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_address_i   (out_o.address),
  .out_valid_res_i (out_o.valid_res)
);
